>>> rtl/core/ssp_pkg.sv
// Shared types, field widths, command codes and default sizes of the shortest path core.
package ssp_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 8;
    localparam int DIST_BITS_DEF    = 16;

    localparam int FUNC_BITS     = 2;
    localparam int VERTEX_BITS   = 5;
    localparam int EDGE_W_BITS   = 8;
    localparam int OUT_DIST_BITS = 16;
    localparam int VCOUNT_BITS   = 5;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 5'd20;

    localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [VERTEX_BITS-1:0] from_vertex;
        logic [VERTEX_BITS-1:0] to_vertex;
        logic [EDGE_W_BITS-1:0] edge_weight;
        logic [VERTEX_BITS-1:0] source;
    } t_cmd;

    typedef struct packed {
        logic [VERTEX_BITS-1:0]   vertex;
        logic [OUT_DIST_BITS-1:0] distance;
        logic                     last;
    } t_result;

endpackage

>>> rtl/core/ssp_ram.sv
// Simple dual-port synchronous RAM with a registered read.
module ssp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/single_source_shortest_path_core.sv
// Shortest path core: weight matrix RAM, distance RAM and the Dijkstra sequencer.
//
// After reset and after every clear command the core sweeps all MAX_VERTICES*MAX_VERTICES
// entries of the weight matrix (1024 by default), one entry a cycle, with busy high; config
// writes are taken meanwhile. An add edge command reads the matrix entry, compares it and
// writes the new weight back if it is lighter or no edge was stored. A run over n =
// min(vertex_count, MAX_VERTICES-1) vertices first seeds the distance RAM, then for each
// settled vertex scans the distance RAM to pick the nearest unsettled vertex, writes once to
// settle it and scans its matrix row against the distance RAM; a round whose scan finds no
// reachable vertex left goes on to a last scan that streams the results. Each scan visits
// every vertex once through the one-read, one-write port pair of the distance RAM. Results
// come out as n consecutive beats, one beat per cycle with o_strobe high, the last flagged;
// the receiver cannot stall them, and busy drops on the cycle of the last beat.
module single_source_shortest_path_core #(
    parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = ssp_pkg::WEIGHT_BITS_DEF,
    parameter int DIST_BITS    = ssp_pkg::DIST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ssp_pkg::t_cmd                   i_cmd,
    output logic                            o_strobe,
    output ssp_pkg::t_result                o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssp_pkg::VCOUNT_BITS-1:0] i_cfg_data
);
    import ssp_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = VW + 1;
    localparam int MDEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW     = $clog2(MDEPTH);
    localparam int MW     = WEIGHT_BITS + 1;
    localparam int DW     = DIST_BITS + 1;
    localparam int SW     = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [CW-1:0]        NMAX     = CW'(MAX_VERTICES - 1);
    localparam logic [AW-1:0]        ALAST    = AW'(MDEPTH - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ADD_RD = 4'd2;
    localparam logic [3:0] S_ADD_WR = 4'd3;
    localparam logic [3:0] S_INIT   = 4'd4;
    localparam logic [3:0] S_SEL    = 4'd5;
    localparam logic [3:0] S_MARK   = 4'd6;
    localparam logic [3:0] S_RELAX  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [VCOUNT_BITS-1:0] r_vcount;
    logic [AW-1:0]          r_caddr, n_caddr;
    logic                   r_iss, n_iss;
    logic                   r_pvalid, n_pvalid;
    logic                   r_out_valid, n_out_valid;

    logic [CW-1:0]          r_n, n_n;
    logic [VW-1:0]          r_src, n_src;
    logic                   r_src_ok, n_src_ok;
    logic [CW-1:0]          r_v, n_v;
    logic [CW-1:0]          r_pv, n_pv;
    logic [CW-1:0]          r_round, n_round;
    logic [DIST_BITS-1:0]   r_best, n_best;
    logic [CW-1:0]          r_bu, n_bu;
    logic [AW-1:0]          r_maddr, n_maddr;
    logic [WEIGHT_BITS-1:0] r_wt, n_wt;
    t_result                r_out, n_out;

    logic                   m_we;
    logic [AW-1:0]          m_waddr, m_raddr;
    logic [MW-1:0]          m_wdata, m_rdata;
    logic                   d_we;
    logic [VW-1:0]          d_waddr, d_raddr;
    logic [DW-1:0]          d_wdata, d_rdata;

    logic [CW-1:0]          cur_n;
    logic                   add_ok;
    logic [AW-1:0]          add_addr;
    logic [AW-1:0]          relax_addr;
    logic [SW-1:0]          path_sum;
    logic [DIST_BITS-1:0]   path_dist;
    logic                   sel_hit;
    logic [CW-1:0]          sel_u;
    logic [CW-1:0]          round_inc;

    ssp_ram #(
        .WIDTH (MW),
        .DEPTH (MDEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    ssp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    assign cur_n = (32'(r_vcount) > MAX_VERTICES - 1) ? NMAX : CW'(r_vcount);

    assign add_ok = (i_cmd.from_vertex != '0) && (i_cmd.to_vertex != '0)
                 && (32'(i_cmd.from_vertex) < MAX_VERTICES)
                 && (32'(i_cmd.to_vertex) < MAX_VERTICES);
    assign add_addr   = AW'(32'(i_cmd.from_vertex) * MAX_VERTICES + 32'(i_cmd.to_vertex));
    assign relax_addr = AW'(32'(r_bu[VW-1:0]) * MAX_VERTICES + 32'(r_v[VW-1:0]));

    assign path_sum  = SW'(r_best) + SW'(m_rdata[WEIGHT_BITS-1:0]);
    assign path_dist = (path_sum >= SW'(DIST_INF)) ? DIST_INF : DIST_BITS'(path_sum);

    assign sel_hit   = !d_rdata[DIST_BITS] && (d_rdata[DIST_BITS-1:0] < r_best);
    assign sel_u     = sel_hit ? r_pv : r_bu;
    assign round_inc = r_round + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_caddr     = r_caddr;
        n_iss       = r_iss;
        n_pvalid    = 1'b0;
        n_out_valid = 1'b0;
        n_n         = r_n;
        n_src       = r_src;
        n_src_ok    = r_src_ok;
        n_v         = r_v;
        n_pv        = r_pv;
        n_round     = r_round;
        n_best      = r_best;
        n_bu        = r_bu;
        n_maddr     = r_maddr;
        n_wt        = r_wt;
        n_out       = r_out;
        m_we        = 1'b0;
        m_waddr     = r_maddr;
        m_wdata     = {1'b1, r_wt};
        m_raddr     = r_maddr;
        d_we        = 1'b0;
        d_waddr     = r_pv[VW-1:0];
        d_wdata     = {d_rdata[DIST_BITS], path_dist};
        d_raddr     = r_v[VW-1:0];

        if ((r_state == S_SEL || r_state == S_RELAX || r_state == S_OUT) && r_iss) begin
            n_pvalid = 1'b1;
            n_pv     = r_v;
            if (r_v == r_n) begin
                n_iss = 1'b0;
            end else begin
                n_v = r_v + CW'(1);
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_caddr;
                m_wdata = '0;
                n_caddr = r_caddr + AW'(1);
                if (r_caddr == ALAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.func)
                        FUNC_ADD: begin
                            if (add_ok) begin
                                n_maddr = add_addr;
                                n_wt    = WEIGHT_BITS'(i_cmd.edge_weight);
                                n_state = S_ADD_RD;
                            end
                        end
                        FUNC_RUN: begin
                            n_n      = cur_n;
                            n_src    = VW'(i_cmd.source);
                            n_src_ok = (i_cmd.source != '0)
                                    && (32'(i_cmd.source) <= 32'(cur_n));
                            n_v      = CW'(1);
                            if (cur_n != '0) begin
                                n_state = S_INIT;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_caddr = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                m_we    = !m_rdata[WEIGHT_BITS] || (r_wt < m_rdata[WEIGHT_BITS-1:0]);
                n_state = S_IDLE;
            end
            S_INIT: begin
                d_we    = 1'b1;
                d_waddr = r_v[VW-1:0];
                d_wdata = {1'b0, (r_src_ok && r_v[VW-1:0] == r_src) ? '0 : DIST_INF};
                if (r_v == r_n) begin
                    n_state = S_SEL;
                    n_v     = CW'(1);
                    n_iss   = 1'b1;
                    n_best  = DIST_INF;
                    n_bu    = '0;
                    n_round = '0;
                end else begin
                    n_v = r_v + CW'(1);
                end
            end
            S_SEL: begin
                if (r_pvalid) begin
                    if (sel_hit) begin
                        n_best = d_rdata[DIST_BITS-1:0];
                        n_bu   = r_pv;
                    end
                    if (r_pv == r_n) begin
                        n_v   = CW'(1);
                        n_iss = (sel_u == '0);
                        if (sel_u == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_MARK;
                        end
                    end
                end
            end
            S_MARK: begin
                d_we    = 1'b1;
                d_waddr = r_bu[VW-1:0];
                d_wdata = {1'b1, r_best};
                n_v     = CW'(1);
                n_iss   = 1'b1;
                n_state = S_RELAX;
            end
            S_RELAX: begin
                m_raddr = relax_addr;
                if (r_pvalid) begin
                    d_we = m_rdata[WEIGHT_BITS] && (path_dist < d_rdata[DIST_BITS-1:0]);
                    if (r_pv == r_n) begin
                        n_round = round_inc;
                        n_v     = CW'(1);
                        n_iss   = 1'b1;
                        n_best  = DIST_INF;
                        n_bu    = '0;
                        if (round_inc == r_n) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SEL;
                        end
                    end
                end
            end
            S_OUT: begin
                if (r_pvalid) begin
                    n_out_valid    = 1'b1;
                    n_out.vertex   = VERTEX_BITS'(r_pv);
                    n_out.distance = OUT_DIST_BITS'(d_rdata[DIST_BITS-1:0]);
                    n_out.last     = (r_pv == r_n);
                    if (r_pv == r_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_caddr     <= '0;
            r_vcount    <= VCOUNT_RESET;
            r_iss       <= 1'b0;
            r_pvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_caddr     <= n_caddr;
            r_iss       <= n_iss;
            r_pvalid    <= n_pvalid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_src    <= n_src;
        r_src_ok <= n_src_ok;
        r_v      <= n_v;
        r_pv     <= n_pv;
        r_round  <= n_round;
        r_best   <= n_best;
        r_bu     <= n_bu;
        r_maddr  <= n_maddr;
        r_wt     <= n_wt;
        r_out    <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_out_valid;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/core/ssp_checker.sv
// Port-level assertions for the shortest path core and their bind.
module ssp_core_assertions (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input ssp_pkg::t_cmd    i_cmd,
    input logic             o_strobe,
    input ssp_pkg::t_result o_result
);
    import ssp_pkg::*;

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_strobe))
        else $error("core not busy clearing or strobing after reset");

    a_beats_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap in result beats before last");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("result beat follows last beat");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_CLEAR) |=> busy)
        else $error("clear command did not start a sweep");

    a_vertex_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.vertex != '0))
        else $error("result beat reports vertex zero");

endmodule

bind single_source_shortest_path_core ssp_core_assertions u_ssp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> bench/ssp_checker.sv
// Checker for the shortest path core: tracks the graph, predicts run distances, compares beats.
`timescale 1ns / 100ps
module ssp_checker
    import ssp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_cmd                   i_cmd,
    input  logic                   i_strobe,
    input  t_result                i_result,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [VCOUNT_BITS-1:0] i_cfg_data,
    output int                     o_pending,
    output int                     o_errors
);

    localparam int NV = MAX_VERTICES_DEF;
    localparam logic [OUT_DIST_BITS-1:0] DIST_UNREACHABLE = '1;

    logic                   edge_valid [NV][NV];
    logic [EDGE_W_BITS-1:0] edge_cost  [NV][NV];
    logic [VCOUNT_BITS-1:0] vertex_limit;
    t_result                dist_expected_q [$];
    int                     errors = 0;

    assign o_errors = errors;

    function automatic void clear_graph();
        for (int a = 0; a < NV; a++) begin
            for (int b = 0; b < NV; b++) begin
                edge_valid[a][b] = 1'b0;
                edge_cost[a][b]  = '0;
            end
        end
    endfunction

    function automatic void keep_lighter_edge(input t_cmd c);
        if (c.from_vertex != 0 && c.to_vertex != 0) begin
            if (!edge_valid[c.from_vertex][c.to_vertex] ||
                    c.edge_weight < edge_cost[c.from_vertex][c.to_vertex]) begin
                edge_valid[c.from_vertex][c.to_vertex] = 1'b1;
                edge_cost[c.from_vertex][c.to_vertex]  = c.edge_weight;
            end
        end
    endfunction

    function automatic void predict_distances(input logic [VERTEX_BITS-1:0] src);
        logic [OUT_DIST_BITS:0] tent [NV];
        logic                   done [NV];
        logic [OUT_DIST_BITS:0] best;
        logic [OUT_DIST_BITS:0] cand;
        int                     n;
        int                     u;
        t_result                r;
        n = int'(vertex_limit);
        for (int v = 0; v < NV; v++) begin
            tent[v] = {1'b0, DIST_UNREACHABLE};
            done[v] = 1'b0;
        end
        if (src >= 1 && src <= n) begin
            tent[src] = '0;
        end
        for (int k = 0; k < n; k++) begin
            u    = 0;
            best = {1'b0, DIST_UNREACHABLE};
            for (int v = 1; v <= n; v++) begin
                if (!done[v] && tent[v] < best) begin
                    best = tent[v];
                    u    = v;
                end
            end
            if (u != 0) begin
                done[u] = 1'b1;
                for (int v = 1; v <= n; v++) begin
                    if (edge_valid[u][v]) begin
                        cand = tent[u] + {9'd0, edge_cost[u][v]};
                        if (cand >= {1'b0, DIST_UNREACHABLE}) begin
                            cand = {1'b0, DIST_UNREACHABLE};
                        end
                        if (cand < tent[v]) begin
                            tent[v] = cand;
                        end
                    end
                end
            end
        end
        for (int v = 1; v <= n; v++) begin
            r.vertex   = v[VERTEX_BITS-1:0];
            r.distance = tent[v][OUT_DIST_BITS-1:0];
            r.last     = (v == n);
            dist_expected_q = {dist_expected_q, r};
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_graph();
            vertex_limit = VCOUNT_RESET;
            dist_expected_q.delete();
        end else begin
            if (i_strobe) begin
                if (dist_expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected beat: vertex %0d distance %0d last %0b",
                                 i_result.vertex, i_result.distance, i_result.last);
                    end
                end else begin
                    want = dist_expected_q.pop_front();
                    if (want.vertex !== i_result.vertex || want.distance !== i_result.distance ||
                            want.last !== i_result.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected vertex %0d distance %0d last %0b, %s",
                                     want.vertex, want.distance, want.last,
                                     $sformatf("got vertex %0d distance %0d last %0b",
                                               i_result.vertex, i_result.distance,
                                               i_result.last));
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                vertex_limit = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                case (i_cmd.func)
                    FUNC_ADD: begin
                        keep_lighter_edge(i_cmd);
                    end
                    FUNC_RUN: begin
                        predict_distances(i_cmd.source);
                    end
                    FUNC_CLEAR: begin
                        clear_graph();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = dist_expected_q.size();
    end

endmodule

>>> bench/tb_single_source_shortest_path_core.sv
// Testbench top for the shortest path core: drives commands and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_single_source_shortest_path_core;
    import ssp_pkg::*;

    localparam logic [FUNC_BITS-1:0] FUNC_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int PHASE_ITEMS   = 23;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   start     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [VCOUNT_BITS-1:0] cfg_data  = '0;
    t_cmd                   cmd       = '0;
    logic                   busy;
    logic                   strobe;
    logic                   cfg_ready;
    t_result                result;
    int                     pending;
    int                     errors;
    int                     cycles      = 0;
    int                     burst_left  = 0;
    int                     vertex_span = 20;

    always #6 i_clk = ~i_clk;

    single_source_shortest_path_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_strobe    (strobe),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ssp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd),
        .i_strobe    (strobe),
        .i_result    (result),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(input logic [FUNC_BITS-1:0] f,
                                      input logic [VERTEX_BITS-1:0] a,
                                      input logic [VERTEX_BITS-1:0] b,
                                      input logic [EDGE_W_BITS-1:0] w,
                                      input logic [VERTEX_BITS-1:0] s);
        t_cmd c;
        c.func        = f;
        c.from_vertex = a;
        c.to_vertex   = b;
        c.edge_weight = w;
        c.source      = s;
        return c;
    endfunction

    function automatic t_cmd random_item(input int n);
        t_cmd c;
        int   hi;
        int   pick;
        c.func        = FUNC_BITS'($urandom);
        c.from_vertex = VERTEX_BITS'($urandom);
        c.to_vertex   = VERTEX_BITS'($urandom);
        c.edge_weight = EDGE_W_BITS'($urandom);
        c.source      = VERTEX_BITS'($urandom);
        hi            = (n == 0) ? 1 : n;
        pick          = $urandom_range(0, 99);
        if (pick < 62) begin
            c.func        = FUNC_ADD;
            c.from_vertex = VERTEX_BITS'($urandom_range(1, hi));
            c.to_vertex   = VERTEX_BITS'($urandom_range(1, hi));
            if ($urandom_range(0, 1) == 0) begin
                c.edge_weight = EDGE_W_BITS'($urandom_range(0, 15));
            end
        end else if (pick < 84) begin
            c.func   = FUNC_RUN;
            c.source = VERTEX_BITS'($urandom_range(1, hi));
        end else if (pick < 86) begin
            c.func = FUNC_CLEAR;
        end else if (c.func == FUNC_CLEAR) begin
            c.func = FUNC_IGNORED;
        end
        return c;
    endfunction

    task automatic send(input t_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_vertex_count(input logic [VCOUNT_BITS-1:0] n);
        drain();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid   <= 1'b0;
        vertex_span = int'(n);
    endtask

    task automatic run_phase(input logic [VCOUNT_BITS-1:0] n);
        write_vertex_count(n);
        repeat (PHASE_ITEMS) send(random_item(vertex_span));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(make_cmd(FUNC_ADD, 1, 2, 10, 0));
        send(make_cmd(FUNC_ADD, 1, 2, 20, 0));
        send(make_cmd(FUNC_ADD, 1, 3, 5, 0));
        send(make_cmd(FUNC_ADD, 3, 2, 4, 0));
        send(make_cmd(FUNC_ADD, 2, 2, 0, 0));
        send(make_cmd(FUNC_ADD, 0, 4, 1, 0));
        send(make_cmd(FUNC_ADD, 4, 0, 1, 0));
        send(make_cmd(FUNC_ADD, 2, 31, 255, 0));
        send(make_cmd(FUNC_ADD, 31, 1, 0, 0));
        send(make_cmd(FUNC_ADD, 2, 4, 255, 0));
        send(make_cmd(FUNC_ADD, 3, 5, 4, 0));
        send(make_cmd(FUNC_ADD, 5, 6, 0, 0));
        send(make_cmd(FUNC_IGNORED, 31, 31, 255, 31));
        send(make_cmd(FUNC_RUN, 0, 0, 0, 1));
        send(make_cmd(FUNC_RUN, 0, 0, 0, 0));
        send(make_cmd(FUNC_RUN, 0, 0, 0, 25));
        send(make_cmd(FUNC_RUN, 31, 31, 255, 20));
        send(make_cmd(FUNC_ADD, 1, 2, 3, 0));
        send(make_cmd(FUNC_RUN, 0, 0, 0, 1));
        send(make_cmd(FUNC_CLEAR, 0, 0, 0, 0));
        send(make_cmd(FUNC_RUN, 0, 0, 0, 1));

        run_phase(5'd31);
        send(make_cmd(FUNC_RUN, 0, 0, 0, 31));
        run_phase(5'd1);
        run_phase(5'd0);
        run_phase(5'd4);
        run_phase(5'd7);
        run_phase(5'd3);
        run_phase(5'd12);
        run_phase(5'd6);
        run_phase(5'd31);
        run_phase(VCOUNT_BITS'($urandom_range(2, 30)));

        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
